// ===== src/vdm_pkg.sv =====
// Package for the vibrato delay modulator: widths, constants, codes and shared types.
package vdm_pkg;

    // Parameter defaults
    localparam int unsigned LINE_DEPTH_DEF = 2048;
    localparam int unsigned PHASE_BITS_DEF = 24;

    // Field and register widths
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned DELAY_W    = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned MAXD_W     = 11;
    localparam int unsigned DEPTH_W    = 16;
    localparam int unsigned STEP_W     = 24;

    // Datapath widths of the front sequencer
    localparam int unsigned OPA_W  = 32;
    localparam int unsigned OPB_W  = 16;
    localparam int unsigned PROD_W = OPA_W + OPB_W;
    localparam int unsigned ACC_W  = 19;

    // Fixed-point constants
    localparam logic [15:0] Q15_ONE   = 16'd32768;
    localparam logic [14:0] Q14_ONE   = 15'd16384;
    localparam logic [31:0] Q30_ONE   = 32'h4000_0000;
    localparam logic [15:0] COEF_T2   = 16'd40426;
    localparam logic [15:0] COEF_T4   = 16'd8312;
    localparam logic [15:0] COEF_T6   = 16'd684;
    localparam logic [15:0] COEF_T8   = 16'd30;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE     = 2'd0,
        CFG_MAX_DELAY  = 2'd1,
        CFG_LFO_DEPTH  = 2'd2,
        CFG_PHASE_STEP = 2'd3
    } t_cfg_index;

    // One configuration write
    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // Work handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic [DELAY_W-1:0]         delay;
        logic                       bypass;
    } t_job;

    // Queue status seen by its two sides
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Front sequencer steps
    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ,
        S_T2,
        S_T4,
        S_C2,
        S_T6,
        S_C4,
        S_T8,
        S_C6,
        S_C8,
        S_DC,
        S_MOD,
        S_HM,
        S_DLY,
        S_PUSH
    } t_front_state;

endpackage

// ===== src/vdm_queue.sv =====
// Two-entry job queue between the front and the back.
module vdm_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  vdm_pkg::t_job          i_job,
    input  logic                   i_pop,
    output vdm_pkg::t_job          o_job,
    output vdm_pkg::t_queue_status o_status
);

    vdm_pkg::t_job r_mem [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;
    logic          do_push;
    logic          do_pop;

    // Qualify the two handshakes
    assign do_push = i_push && (r_count != 2'd2);
    assign do_pop  = i_pop && (r_count != 2'd0);

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 2'd1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    // Store the pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    assign o_job          = r_mem[r_rd];
    assign o_status.full  = (r_count == 2'd2);
    assign o_status.empty = (r_count == 2'd0);

endmodule

// ===== src/vdm_front.sv =====
// Front part: accepts samples, holds the LFO and computes the read delay per item.
module vdm_front #(
    parameter int unsigned LINE_DEPTH = vdm_pkg::LINE_DEPTH_DEF,
    parameter int unsigned PHASE_BITS = vdm_pkg::PHASE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  vdm_pkg::t_cfg_wr                  i_cfg,
    input  logic                              i_push,
    input  logic signed [vdm_pkg::SAMPLE_W-1:0] i_sample,
    output logic                              o_full,
    input  vdm_pkg::t_queue_status            i_qstat,
    output logic                              o_q_push,
    output vdm_pkg::t_job                     o_job
);

    localparam int unsigned PHASE_SHIFT = 32 - PHASE_BITS;

    vdm_pkg::t_front_state r_state;
    vdm_pkg::t_front_state n_state;

    // Configuration registers
    logic                          r_enable;
    logic [vdm_pkg::MAXD_W-1:0]    r_max_delay;
    logic [vdm_pkg::DEPTH_W-1:0]   r_depth;
    logic [vdm_pkg::STEP_W-1:0]    r_step;

    // LFO and per-item working registers
    logic [PHASE_BITS-1:0]         r_phase;
    logic signed [vdm_pkg::SAMPLE_W-1:0] r_sample;
    logic                          r_bypass;
    logic [14:0]                   r_t;
    logic                          r_neg;
    logic [15:0]                   r_t2;
    logic [15:0]                   r_t4;
    logic [15:0]                   r_t6;
    logic [15:0]                   r_t8;
    logic signed [vdm_pkg::ACC_W-1:0] r_acc;
    logic [31:0]                   r_m;
    logic [vdm_pkg::DELAY_W-1:0]   r_delay;
    logic [vdm_pkg::PROD_W-1:0]    r_prod;

    // Combinational helpers
    logic                          accept;
    logic [31:0]                   p32;
    logic [15:0]                   p16;
    logic [1:0]                    quad;
    logic [14:0]                   t_sel;
    logic [PHASE_BITS-1:0]         step_ext;
    logic [15:0]                   t2_now;
    logic [16:0]                   p15;
    logic signed [vdm_pkg::ACC_W-1:0] term;
    logic [15:0]                   f_clamp;
    logic [15:0]                   depth_sat;
    logic [11:0]                   d_raw;
    logic [vdm_pkg::DELAY_W-1:0]   d_sat;
    logic [vdm_pkg::OPA_W-1:0]     op_a;
    logic [vdm_pkg::OPB_W-1:0]     op_b;

    assign o_full = (r_state != vdm_pkg::S_IDLE);
    assign accept = i_push && !o_full;

    // Split the phase into quadrant and position within it
    assign p32      = 32'(r_phase) << PHASE_SHIFT;
    assign p16      = p32[31:16];
    assign quad     = p16[15:14];
    assign t_sel    = quad[0] ? (vdm_pkg::Q14_ONE - {1'b0, p16[13:0]}) : {1'b0, p16[13:0]};
    assign step_ext = PHASE_BITS'(r_step);

    // Take scaled terms out of the last product
    assign t2_now = r_prod[28:13];
    assign p15    = r_prod[31:15];
    assign term   = $signed({2'b00, p15});

    // Clamp the quarter cosine and the depth
    always_comb begin
        if (r_acc < 0) begin
            f_clamp = 16'd0;
        end else if (r_acc > $signed({3'b000, vdm_pkg::Q15_ONE})) begin
            f_clamp = vdm_pkg::Q15_ONE;
        end else begin
            f_clamp = r_acc[15:0];
        end
        depth_sat = (r_depth > vdm_pkg::Q15_ONE) ? vdm_pkg::Q15_ONE : r_depth;
    end

    // Form the delay and hold it inside the ring
    assign d_raw = 12'd1 + r_prod[41:30];
    assign d_sat = (32'(d_raw) > 32'(LINE_DEPTH - 1)) ? vdm_pkg::DELAY_W'(LINE_DEPTH - 1)
                                                      : vdm_pkg::DELAY_W'(d_raw);

    // Select the multiplier operands for each step
    always_comb begin
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            vdm_pkg::S_SQ: begin
                op_a = 32'(r_t);
                op_b = 16'(r_t);
            end
            vdm_pkg::S_T2: begin
                op_a = 32'(t2_now);
                op_b = t2_now;
            end
            vdm_pkg::S_T4: begin
                op_a = 32'(vdm_pkg::COEF_T2);
                op_b = r_t2;
            end
            vdm_pkg::S_C2: begin
                op_a = 32'(r_t4);
                op_b = r_t2;
            end
            vdm_pkg::S_T6: begin
                op_a = 32'(vdm_pkg::COEF_T4);
                op_b = r_t4;
            end
            vdm_pkg::S_C4: begin
                op_a = 32'(r_t4);
                op_b = r_t4;
            end
            vdm_pkg::S_T8: begin
                op_a = 32'(vdm_pkg::COEF_T6);
                op_b = r_t6;
            end
            vdm_pkg::S_C6: begin
                op_a = 32'(vdm_pkg::COEF_T8);
                op_b = r_t8;
            end
            vdm_pkg::S_DC: begin
                op_a = 32'(depth_sat);
                op_b = f_clamp;
            end
            vdm_pkg::S_HM: begin
                op_a = r_m;
                op_b = 16'(r_max_delay[vdm_pkg::MAXD_W-1:1]);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // Drive the queue push
    always_comb begin
        o_q_push      = (r_state == vdm_pkg::S_PUSH) && !i_qstat.full;
        o_job.sample  = r_sample;
        o_job.delay   = r_delay;
        o_job.bypass  = r_bypass;
    end

    // Step through the sequence
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vdm_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = r_enable ? vdm_pkg::S_SQ : vdm_pkg::S_PUSH;
                end
            end
            vdm_pkg::S_SQ:  n_state = vdm_pkg::S_T2;
            vdm_pkg::S_T2:  n_state = vdm_pkg::S_T4;
            vdm_pkg::S_T4:  n_state = vdm_pkg::S_C2;
            vdm_pkg::S_C2:  n_state = vdm_pkg::S_T6;
            vdm_pkg::S_T6:  n_state = vdm_pkg::S_C4;
            vdm_pkg::S_C4:  n_state = vdm_pkg::S_T8;
            vdm_pkg::S_T8:  n_state = vdm_pkg::S_C6;
            vdm_pkg::S_C6:  n_state = vdm_pkg::S_C8;
            vdm_pkg::S_C8:  n_state = vdm_pkg::S_DC;
            vdm_pkg::S_DC:  n_state = vdm_pkg::S_MOD;
            vdm_pkg::S_MOD: n_state = vdm_pkg::S_HM;
            vdm_pkg::S_HM:  n_state = vdm_pkg::S_DLY;
            vdm_pkg::S_DLY: n_state = vdm_pkg::S_PUSH;
            vdm_pkg::S_PUSH: begin
                if (!i_qstat.full) begin
                    n_state = vdm_pkg::S_IDLE;
                end
            end
            default: n_state = vdm_pkg::S_IDLE;
        endcase
    end

    // Hold state, configuration and LFO phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vdm_pkg::S_IDLE;
            r_enable    <= 1'b0;
            r_max_delay <= '0;
            r_depth     <= '0;
            r_step      <= '0;
            r_phase     <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg.we) begin
                unique case (vdm_pkg::t_cfg_index'(i_cfg.index))
                    vdm_pkg::CFG_ENABLE:     r_enable    <= i_cfg.data[0];
                    vdm_pkg::CFG_MAX_DELAY:  r_max_delay <= i_cfg.data[vdm_pkg::MAXD_W-1:0];
                    vdm_pkg::CFG_LFO_DEPTH:  r_depth     <= i_cfg.data[vdm_pkg::DEPTH_W-1:0];
                    vdm_pkg::CFG_PHASE_STEP: r_step      <= i_cfg.data[vdm_pkg::STEP_W-1:0];
                endcase
            end
            // Advance the phase after its value was taken for this item
            if (accept && r_enable) begin
                r_phase <= r_phase + step_ext;
            end
        end
    end

    // Work registers of the sequence
    always_ff @(posedge i_clk) begin
        r_prod <= vdm_pkg::PROD_W'(op_a) * vdm_pkg::PROD_W'(op_b);
        unique case (r_state)
            vdm_pkg::S_IDLE: begin
                if (accept) begin
                    r_sample <= i_sample;
                    r_bypass <= !r_enable;
                    r_t      <= t_sel;
                    r_neg    <= quad[1] ^ quad[0];
                    r_delay  <= '0;
                end
            end
            vdm_pkg::S_T2:  r_t2  <= t2_now;
            vdm_pkg::S_T4:  r_t4  <= p15[15:0];
            vdm_pkg::S_C2:  r_acc <= $signed({3'b000, vdm_pkg::Q15_ONE}) - term;
            vdm_pkg::S_T6:  r_t6  <= p15[15:0];
            vdm_pkg::S_C4:  r_acc <= r_acc + term;
            vdm_pkg::S_T8:  r_t8  <= p15[15:0];
            vdm_pkg::S_C6:  r_acc <= r_acc - term;
            vdm_pkg::S_C8:  r_acc <= r_acc + term;
            vdm_pkg::S_MOD: begin
                r_m <= r_neg ? (vdm_pkg::Q30_ONE + r_prod[31:0])
                             : (vdm_pkg::Q30_ONE - r_prod[31:0]);
            end
            vdm_pkg::S_DLY: r_delay <= d_sat;
            default: begin
            end
        endcase
    end

endmodule

// ===== src/vdm_back.sv =====
// Back part: writes the delay ring, reads the delayed sample and holds the result.
module vdm_back #(
    parameter int unsigned LINE_DEPTH = vdm_pkg::LINE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  vdm_pkg::t_job                       i_job,
    input  vdm_pkg::t_queue_status              i_qstat,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic signed [vdm_pkg::SAMPLE_W-1:0] o_sample
);

    localparam int unsigned AW     = $clog2(LINE_DEPTH);
    localparam int unsigned AW1    = AW + 1;
    localparam int unsigned FILL_W = $clog2(LINE_DEPTH + 1);

    logic signed [vdm_pkg::SAMPLE_W-1:0] r_ring [LINE_DEPTH];
    logic [AW-1:0]                       r_wp;
    logic [FILL_W-1:0]                   r_fill;
    logic                                r_busy;
    logic                                r_bypass;
    logic                                r_zero;
    logic signed [vdm_pkg::SAMPLE_W-1:0] r_sample_d;
    logic signed [vdm_pkg::SAMPLE_W-1:0] r_rdata;
    logic                                r_out_valid;
    logic signed [vdm_pkg::SAMPLE_W-1:0] r_out;

    logic                                issue;
    logic [AW1-1:0]                      wp_ext;
    logic [AW1-1:0]                      d_ext;
    logic [AW1-1:0]                      rd_sum;
    logic [AW-1:0]                       rd_addr;
    logic                                unwritten;

    // Take a job when the read stage and the result slot can move
    assign issue   = !i_qstat.empty && !r_busy && (!r_out_valid || i_pop);
    assign o_q_pop = issue;

    // Read address behind the write pointer, modulo the ring depth
    assign wp_ext  = AW1'(r_wp);
    assign d_ext   = AW1'(i_job.delay);
    assign rd_sum  = (wp_ext >= d_ext) ? (wp_ext - d_ext) : (wp_ext + AW1'(LINE_DEPTH) - d_ext);
    assign rd_addr = rd_sum[AW-1:0];

    // Entries never written read as zero
    assign unwritten = (32'(i_job.delay) > 32'(r_fill));

    // Write the ring and read the delayed entry
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_ring[r_wp] <= i_job.sample;
            r_rdata      <= r_ring[rd_addr];
            r_sample_d   <= i_job.sample;
            r_bypass     <= i_job.bypass;
            r_zero       <= unwritten;
        end
        if (r_busy) begin
            r_out <= r_bypass ? r_sample_d : (r_zero ? '0 : r_rdata);
        end
    end

    // Advance the pointer, the fill count and the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_fill      <= '0;
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy <= issue;
            if (issue) begin
                r_wp <= (r_wp == AW'(LINE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
                if (r_fill != FILL_W'(LINE_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_busy) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_sample = r_out;

endmodule

// ===== src/vibrato_delay_modulator.sv =====
// Vibrato delay modulator: LFO-swept read delay over a circular sample ring.
// Enabled: the front sequencer runs its steps on one shared 32x16 multiplier, one
// step a cycle but for a stall in push while the queue is full, and takes no new
// sample until the last is pushed. Disabled: a sample goes straight to push.
// Synchronous active-low reset clears configuration, LFO phase, pointers and the
// ring fill count; unwritten ring entries read as zero, so no clearing pass runs.
module vibrato_delay_modulator #(
    parameter int unsigned LINE_DEPTH = vdm_pkg::LINE_DEPTH_DEF,
    parameter int unsigned PHASE_BITS = vdm_pkg::PHASE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [vdm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [vdm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                push,
    output logic                                full,
    input  logic signed [vdm_pkg::SAMPLE_W-1:0] i_in_sample,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [vdm_pkg::SAMPLE_W-1:0] o_out_sample
);

    vdm_pkg::t_cfg_wr       cfg;
    vdm_pkg::t_queue_status qstat;
    vdm_pkg::t_job          job_in;
    vdm_pkg::t_job          job_out;
    logic                   q_push;
    logic                   q_pop;

    // Bundle the configuration write
    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    vdm_front #(
        .LINE_DEPTH (LINE_DEPTH),
        .PHASE_BITS (PHASE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (push),
        .i_sample (i_in_sample),
        .o_full   (full),
        .i_qstat  (qstat),
        .o_q_push (q_push),
        .o_job    (job_in)
    );

    vdm_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (q_push),
        .i_job    (job_in),
        .i_pop    (q_pop),
        .o_job    (job_out),
        .o_status (qstat)
    );

    vdm_back #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (job_out),
        .i_qstat  (qstat),
        .o_q_pop  (q_pop),
        .i_pop    (pop),
        .o_empty  (empty),
        .o_sample (o_out_sample)
    );

endmodule
